FILE: rtl/i2cram_pkg.sv
package i2cram_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] TICKS_RESET = 16'd1;
  localparam logic [CFG_W-1:0] POLL_RESET = 16'd1000;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_DATA  = 2'd3
  } opcode_t;

  typedef enum logic [0:0] {
    REG_TICKS_PER_PHASE = 1'b0,
    REG_ACK_POLL_LIMIT  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_DEV  = 2'd0,
    KIND_REG  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_RDEV = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_OK       = 3'd0,
    OUT_DEVICE   = 3'd1,
    OUT_REGISTER = 3'd2,
    OUT_DATA     = 3'd3,
    OUT_RD_ADDR  = 3'd4
  } outcome_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_HI,
    ST_START_FALL,
    ST_START_LOW,
    ST_RS_REL,
    ST_RS_HI,
    ST_RS_FALL,
    ST_RS_LOW,
    ST_TX_LOW,
    ST_TX_HIGH,
    ST_ACK_LOW,
    ST_ACK_HIGH,
    ST_WAIT,
    ST_RX_LOW,
    ST_RX_HIGH,
    ST_MACK_LOW,
    ST_MACK_HIGH,
    ST_STOP_LOW,
    ST_STOP_HIGH,
    ST_STOP_REL
  } state_t;

  typedef struct packed {
    opcode_t              op;
    logic [DATA_W-1:0]    device_address;
    logic [DATA_W-1:0]    register_address;
    logic [COUNT_W-1:0]   byte_count;
    logic [DATA_W-1:0]    write_byte;
    logic                 sda_sample;
  } item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 wants_byte;
    logic                 read_valid;
    logic [DATA_W-1:0]    read_data;
    logic                 read_last;
    logic                 finished;
    outcome_t             outcome;
  } result_t;

  function automatic outcome_t kind_outcome(input kind_t kind);
    outcome_t oc;
    unique case (kind)
      KIND_DEV:  oc = OUT_DEVICE;
      KIND_REG:  oc = OUT_REGISTER;
      KIND_DATA: oc = OUT_DATA;
      KIND_RDEV: oc = OUT_RD_ADDR;
      default:   oc = OUT_OK;
    endcase
    return oc;
  endfunction

endpackage

FILE: rtl/i2cram_front.sv
module i2cram_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [i2cram_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [1:0]                          in_user,
  output logic                                out_valid,
  input  logic                                out_ready,
  output i2cram_pkg::item_t                   out_item
);
  import i2cram_pkg::*;

  logic  valid;
  item_t item;
  item_t item_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // unpack and classify the incoming item
  always_comb begin
    item_next.op               = opcode_t'(in_user);
    item_next.device_address   = in_data[7:0];
    item_next.register_address = in_data[15:8];
    item_next.byte_count       = in_data[31:16];
    item_next.write_byte       = in_data[39:32];
    item_next.sda_sample       = in_data[40];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

FILE: rtl/i2cram_queue.sv
module i2cram_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  i2cram_pkg::item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output i2cram_pkg::item_t pop_item
);
  import i2cram_pkg::*;

  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/i2cram_back.sv
module i2cram_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [i2cram_pkg::CFG_W-1:0]      ticks_per_phase,
  input  logic [i2cram_pkg::CFG_W-1:0]      ack_poll_limit,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  i2cram_pkg::item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output i2cram_pkg::result_t               out_res
);
  import i2cram_pkg::*;

  state_t              state, state_next;
  kind_t               kind, kind_next;
  logic [COUNT_W-1:0]  divider, divider_next;
  logic [2:0]          bit_idx, bit_idx_next;
  logic [DATA_W-1:0]   shift, shift_next;
  logic [COUNT_W-1:0]  bytes_left, bytes_left_next;
  logic [COUNT_W-1:0]  poll, poll_next;
  logic [DATA_W-1:0]   saved_device, saved_device_next;
  logic [DATA_W-1:0]   saved_register, saved_register_next;
  logic                pend_valid, pend_valid_next;
  logic [DATA_W-1:0]   pend_data, pend_data_next;
  logic                is_read, is_read_next;

  logic                pop;
  logic [CFG_W-1:0]    tick_limit;
  logic                phase_end;
  logic                poll_over;
  logic [DATA_W-1:0]   rx_byte;
  logic                rv;
  logic [DATA_W-1:0]   rd;
  logic                rl;
  logic                fin;
  outcome_t            oc;
  result_t             res_next;

  assign pop        = in_valid && (!out_valid || out_ready);
  assign in_ready   = !out_valid || out_ready;
  assign tick_limit = (ticks_per_phase == '0) ? CFG_W'(1) : ticks_per_phase;
  assign phase_end  = ({1'b0, divider} + 17'd1) >= {1'b0, tick_limit};
  assign poll_over  = ({1'b0, poll} + 17'd1) >= {1'b0, ack_poll_limit};
  assign rx_byte    = {shift[DATA_W-2:0], in_item.sda_sample};

  // next state and datapath
  always_comb begin
    state_next          = state;
    kind_next           = kind;
    divider_next        = divider;
    bit_idx_next        = bit_idx;
    shift_next          = shift;
    bytes_left_next     = bytes_left;
    poll_next           = poll;
    saved_device_next   = saved_device;
    saved_register_next = saved_register;
    pend_valid_next     = pend_valid;
    pend_data_next      = pend_data;
    is_read_next        = is_read;
    rv  = 1'b0;
    rd  = '0;
    rl  = 1'b0;
    fin = 1'b0;
    oc  = OUT_OK;
    if (pop) begin
      unique case (in_item.op)
        OP_WRITE, OP_READ: begin
          if (state == ST_IDLE) begin
            is_read_next        = (in_item.op == OP_READ);
            saved_device_next   = in_item.device_address;
            saved_register_next = in_item.register_address;
            bytes_left_next     = (in_item.byte_count == '0) ? COUNT_W'(1)
                                                             : in_item.byte_count;
            pend_valid_next     = 1'b0;
            poll_next           = '0;
            bit_idx_next        = '0;
            shift_next          = in_item.device_address;
            divider_next        = '0;
            state_next          = ST_START_HI;
          end
        end
        OP_DATA: begin
          if (state != ST_IDLE && !is_read && bytes_left != '0) begin
            pend_valid_next = 1'b1;
            pend_data_next  = in_item.write_byte;
          end
        end
        OP_TICK: begin
          if (state != ST_IDLE) begin
            if (!phase_end) begin
              divider_next = divider + COUNT_W'(1);
            end else begin
              divider_next = '0;
              unique case (state)
                ST_START_HI:   state_next = ST_START_FALL;
                ST_START_FALL: state_next = ST_START_LOW;
                ST_START_LOW: begin
                  shift_next   = saved_device;
                  bit_idx_next = '0;
                  kind_next    = KIND_DEV;
                  state_next   = ST_TX_LOW;
                end
                ST_RS_REL:  state_next = ST_RS_HI;
                ST_RS_HI:   state_next = ST_RS_FALL;
                ST_RS_FALL: state_next = ST_RS_LOW;
                ST_RS_LOW: begin
                  shift_next   = saved_device + DATA_W'(1);
                  bit_idx_next = '0;
                  kind_next    = KIND_RDEV;
                  state_next   = ST_TX_LOW;
                end
                ST_WAIT: begin
                  if (pend_valid) begin
                    pend_valid_next = 1'b0;
                    bytes_left_next = bytes_left - COUNT_W'(1);
                    shift_next      = pend_data;
                    bit_idx_next    = '0;
                    kind_next       = KIND_DATA;
                    state_next      = ST_TX_LOW;
                  end
                end
                ST_RX_LOW: state_next = ST_RX_HIGH;
                ST_RX_HIGH: begin
                  shift_next = rx_byte;
                  if (bit_idx == 3'd7) begin
                    bit_idx_next    = '0;
                    rv              = 1'b1;
                    rd              = rx_byte;
                    rl              = (bytes_left <= COUNT_W'(1));
                    bytes_left_next = (bytes_left == '0) ? '0 : bytes_left - COUNT_W'(1);
                    state_next      = ST_MACK_LOW;
                  end else begin
                    bit_idx_next = bit_idx + 3'd1;
                    state_next   = ST_RX_LOW;
                  end
                end
                ST_MACK_LOW: state_next = ST_MACK_HIGH;
                ST_MACK_HIGH: begin
                  if (bytes_left != '0) begin
                    shift_next   = '0;
                    bit_idx_next = '0;
                    state_next   = ST_RX_LOW;
                  end else begin
                    shift_next = DATA_W'(OUT_OK);
                    poll_next  = '0;
                    state_next = ST_STOP_LOW;
                  end
                end
                ST_STOP_LOW:  state_next = ST_STOP_HIGH;
                ST_STOP_HIGH: state_next = ST_STOP_REL;
                ST_STOP_REL: begin
                  fin             = 1'b1;
                  oc              = outcome_t'(shift[2:0]);
                  shift_next      = '0;
                  is_read_next    = 1'b0;
                  pend_valid_next = 1'b0;
                  state_next      = ST_IDLE;
                end
                ST_TX_LOW: state_next = ST_TX_HIGH;
                ST_TX_HIGH: begin
                  shift_next = {shift[DATA_W-2:0], 1'b0};
                  if (bit_idx == 3'd7) begin
                    bit_idx_next = '0;
                    poll_next    = '0;
                    state_next   = ST_ACK_LOW;
                  end else begin
                    bit_idx_next = bit_idx + 3'd1;
                    state_next   = ST_TX_LOW;
                  end
                end
                ST_ACK_LOW: state_next = ST_ACK_HIGH;
                ST_ACK_HIGH: begin
                  if (in_item.sda_sample) begin
                    if (poll_over) begin
                      shift_next = DATA_W'(kind_outcome(kind));
                      poll_next  = '0;
                      state_next = ST_STOP_LOW;
                    end else begin
                      poll_next  = poll + COUNT_W'(1);
                      state_next = ST_ACK_LOW;
                    end
                  end else begin
                    poll_next = '0;
                    priority if (kind == KIND_DEV) begin
                      shift_next   = saved_register;
                      bit_idx_next = '0;
                      kind_next    = KIND_REG;
                      state_next   = ST_TX_LOW;
                    end else if (kind == KIND_RDEV) begin
                      shift_next   = '0;
                      bit_idx_next = '0;
                      state_next   = ST_RX_LOW;
                    end else if (kind == KIND_REG && is_read) begin
                      state_next = ST_RS_REL;
                    end else if (bytes_left == '0) begin
                      shift_next = DATA_W'(OUT_OK);
                      state_next = ST_STOP_LOW;
                    end else begin
                      state_next = ST_WAIT;
                    end
                  end
                end
                default: state_next = ST_IDLE;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // bus levels and status after the step
  always_comb begin
    res_next.scl_level = 1'b1;
    res_next.sda_level = 1'b1;
    unique case (state_next)
      ST_START_FALL, ST_RS_FALL, ST_STOP_HIGH: begin
        res_next.sda_level = 1'b0;
      end
      ST_START_LOW, ST_RS_LOW, ST_STOP_LOW: begin
        res_next.scl_level = 1'b0;
        res_next.sda_level = 1'b0;
      end
      ST_RS_REL, ST_WAIT, ST_RX_LOW: begin
        res_next.scl_level = 1'b0;
      end
      ST_MACK_LOW, ST_MACK_HIGH: begin
        res_next.scl_level = (state_next == ST_MACK_HIGH);
        res_next.sda_level = (bytes_left_next == '0);
      end
      ST_TX_LOW, ST_TX_HIGH: begin
        res_next.scl_level = (state_next == ST_TX_HIGH);
        res_next.sda_level = shift_next[DATA_W-1];
      end
      ST_ACK_LOW: begin
        res_next.scl_level = 1'b0;
      end
      default: ;
    endcase
    res_next.busy_res   = (state_next != ST_IDLE);
    res_next.wants_byte = (state_next != ST_IDLE) && !is_read_next &&
                          (bytes_left_next != '0) && !pend_valid_next;
    res_next.read_valid = rv;
    res_next.read_data  = rd;
    res_next.read_last  = rl;
    res_next.finished   = fin;
    res_next.outcome    = oc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      kind           <= KIND_DEV;
      divider        <= '0;
      bit_idx        <= '0;
      shift          <= '0;
      bytes_left     <= '0;
      poll           <= '0;
      saved_device   <= '0;
      saved_register <= '0;
      pend_valid     <= 1'b0;
      pend_data      <= '0;
      is_read        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      kind           <= kind_next;
      divider        <= divider_next;
      bit_idx        <= bit_idx_next;
      shift          <= shift_next;
      bytes_left     <= bytes_left_next;
      poll           <= poll_next;
      saved_device   <= saved_device_next;
      saved_register <= saved_register_next;
      pend_valid     <= pend_valid_next;
      pend_data      <= pend_data_next;
      is_read        <= is_read_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

endmodule

FILE: rtl/i2c_register_access_master.sv
// channel   | direction | tdata / tuser contents
// s_axis    | in        | command, tick or data item, one per handshake
// m_axis    | out       | bus levels and status, one item per input item
// cfg       | in        | index 0 ticks_per_phase, index 1 ack_poll_limit
//
// one item per clock sustained in both directions while m_axis_tready stays high
// an item taken on s_axis passes the front register, the two-entry queue, then
// the output register of the bus sequencer before it is valid on m_axis
// rst is synchronous and empties all stages; registers return to defaults
// a stall on m_axis fills the queue before s_axis_tready drops
module i2c_register_access_master (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] device_address, [15:8] register_address, [31:16] byte_count,
  // [39:32] write_byte, [40] sda_sample, [47:41] zero
  input  logic [i2cram_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] wants_byte,
  // [4] read_valid, [12:5] read_data, [13] finished, [16:14] outcome,
  // [23:17] zero
  output logic [i2cram_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [i2cram_pkg::CFG_W-1:0]        cfg_data
);
  import i2cram_pkg::*;

  logic [CFG_W-1:0] ticks_per_phase;
  logic [CFG_W-1:0] ack_poll_limit;
  logic             f_valid;
  logic             q_ready;
  item_t            f_item;
  logic             q_valid;
  logic             b_ready;
  item_t            q_item;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= TICKS_RESET;
      ack_poll_limit  <= POLL_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TICKS_PER_PHASE: ticks_per_phase <= cfg_data;
        REG_ACK_POLL_LIMIT:  ack_poll_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cram_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (f_valid),
    .out_ready (q_ready),
    .out_item  (f_item)
  );

  i2cram_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (q_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (b_ready),
    .pop_item   (q_item)
  );

  i2cram_back u_back (
    .clk             (clk),
    .rst             (rst),
    .ticks_per_phase (ticks_per_phase),
    .ack_poll_limit  (ack_poll_limit),
    .in_valid        (q_valid),
    .in_ready        (b_ready),
    .in_item         (q_item),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_res         (res)
  );

  assign m_axis_tdata = {7'd0, res.outcome, res.finished, res.read_data, res.read_valid,
                         res.wants_byte, res.busy_res, res.sda_level, res.scl_level};
  assign m_axis_tlast = res.read_last;

  // a full queue is never empty
  a_queue_full: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !q_ready) |-> q_valid)
    else $error("queue refuses a push while empty");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[13]) |-> !m_axis_tdata[2])
    else $error("transfer finished but still busy");

  a_read_not_finish: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[13]))
    else $error("read byte and finish in one item");

  a_last_has_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[4])
    else $error("read_last without a read byte");

endmodule
